/* rtl/core/tilt_motion_filter_macros.svh */
// assertion macros shared by the tilt motion filter checkers
// expects clk and rst_n in the scope where a macro is used
`ifndef TILT_MOTION_FILTER_MACROS_SVH
`define TILT_MOTION_FILTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TMF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmf: same-cycle check failed");

// next-cycle implication, disabled during reset
`define TMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmf: next-cycle check failed");

`endif

/* rtl/core/tmf_pkg.sv */
// constants and types of the tilt motion filter
// no dependencies
package tmf_pkg;

    localparam int TMF_SAMPLE_BITS = 16;
    localparam int TMF_CFG_W       = 16;
    localparam int TMF_ADDR_W      = 4;
    localparam int TMF_DATA_W      = 32;

    // shifts of the two smoothers: quarter and one-sixteenth weight
    localparam int TMF_AVG_SHIFT  = 2;
    localparam int TMF_TILT_SHIFT = 4;

    localparam logic                        TMF_ENABLE_RST      = 1'b1;
    localparam logic [TMF_CFG_W-1:0]        TMF_MOTION_THR_RST  = 16'd40;
    localparam logic [TMF_CFG_W-1:0]        TMF_REST_THR_RST    = 16'd5;
    localparam logic signed [TMF_CFG_W-1:0] TMF_TILT_OFFSET_RST = 16'sd1024;

    typedef enum logic [1:0] {
        REG_ENABLE      = 2'd0,
        REG_MOTION_THR  = 2'd1,
        REG_REST_THR    = 2'd2,
        REG_TILT_OFFSET = 2'd3
    } tmf_reg_idx_t;

endpackage

/* rtl/core/tmf_sample_if.sv */
// input channel of the tilt motion filter: one three-axis sample per word
// depends on tmf_pkg
interface tmf_sample_if
    import tmf_pkg::*;
#(
    parameter int SAMPLE_BITS = TMF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

/* rtl/core/tmf_result_if.sv */
// output channel of the tilt motion filter: motion and tilt per word
// depends on tmf_pkg
interface tmf_result_if
    import tmf_pkg::*;
#(
    parameter int SAMPLE_BITS = TMF_SAMPLE_BITS
);
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_BITS:0] motion_x;
    logic signed [SAMPLE_BITS:0] motion_y;
    logic signed [SAMPLE_BITS:0] motion_z;
    logic signed [SAMPLE_BITS:0] tilt_a;
    logic signed [SAMPLE_BITS:0] tilt_b;

    modport source (output valid, output motion_x, output motion_y, output motion_z,
                    output tilt_a, output tilt_b, input ready);
    modport sink   (input valid, input motion_x, input motion_y, input motion_z,
                    input tilt_a, input tilt_b, output ready);
endinterface

/* rtl/core/tilt_motion_filter.sv */
// tilt motion filter top level: deadband moving average per axis, two tilt smoothers
// depends on tmf_pkg, tmf_sample_if, tmf_result_if
//
// The block takes one sample word per clock while ready is high and returns
// one result word per sample: the sample lands in an input register, and the
// per-axis deadband, quarter-weight average and the two tilt smoothers run
// in one pass of logic into the result register, updating the filter state
// in the same edge. A full result register that is not taken holds the
// input register, and ready drops only when both are full. Configuration is
// through the APB port; writing enable to 0 makes every following word
// clear the filter state and return all zeros.
module tilt_motion_filter
    import tmf_pkg::*;
#(
    parameter int SAMPLE_BITS = TMF_SAMPLE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [TMF_ADDR_W-1:0] paddr,
    input  logic [TMF_DATA_W-1:0] pwdata,
    output logic [TMF_DATA_W-1:0] prdata,
    output logic                  pready,
    tmf_sample_if.sink            in_ch,
    tmf_result_if.source          out_ch
);

    localparam int SW = SAMPLE_BITS;
    localparam int AW = SAMPLE_BITS + 2;                         // average state
    localparam int XW = SAMPLE_BITS + 3;                         // average arithmetic
    localparam int MW = (XW > TMF_CFG_W) ? XW : TMF_CFG_W;       // magnitude compare
    localparam int TW = ((SW > TMF_CFG_W) ? SW : TMF_CFG_W) + 3; // tilt arithmetic
    localparam logic signed [XW-1:0] AVG_BIAS = XW'((1 << TMF_AVG_SHIFT) - 1);

    // configuration registers
    logic                        enable_reg;
    logic [TMF_CFG_W-1:0]        motion_thr_reg;
    logic [TMF_CFG_W-1:0]        rest_thr_reg;
    logic signed [TMF_CFG_W-1:0] tilt_offset_reg;
    logic                        cfg_wr;
    tmf_reg_idx_t                cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = tmf_reg_idx_t'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= TMF_ENABLE_RST;
            motion_thr_reg  <= TMF_MOTION_THR_RST;
            rest_thr_reg    <= TMF_REST_THR_RST;
            tilt_offset_reg <= TMF_TILT_OFFSET_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ENABLE:      enable_reg      <= pwdata[0];
                REG_MOTION_THR:  motion_thr_reg  <= pwdata[TMF_CFG_W-1:0];
                REG_REST_THR:    rest_thr_reg    <= pwdata[TMF_CFG_W-1:0];
                REG_TILT_OFFSET: tilt_offset_reg <= $signed(pwdata[TMF_CFG_W-1:0]);
                default:         enable_reg      <= enable_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ENABLE:      prdata = TMF_DATA_W'(enable_reg);
            REG_MOTION_THR:  prdata = TMF_DATA_W'(motion_thr_reg);
            REG_REST_THR:    prdata = TMF_DATA_W'(rest_thr_reg);
            REG_TILT_OFFSET: prdata = TMF_DATA_W'(tilt_offset_reg);
            default:         prdata = '0;
        endcase
    end

    // handshake and stage control
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_adv;
    logic in_acc;
    logic proc;

    assign out_adv     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || out_adv;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign proc        = out_adv && s1_valid_reg;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_ch.ready)
        begin
            s1_valid_next = in_ch.valid;
        end
        if (out_adv)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    logic signed [SW-1:0] samp_reg [3];

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            samp_reg[0] <= in_ch.accel_x;
            samp_reg[1] <= in_ch.accel_y;
            samp_reg[2] <= in_ch.accel_z;
        end
    end

    // per-axis deadband and quarter-weight average
    logic signed [SW:0] motion_res [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        logic signed [SW-1:0] prev_reg, prev_next;
        logic signed [AW-1:0] avg_reg, avg_next;
        logic signed [XW-1:0] diff, diff_abs, diff_dz, err, quarter, avg_sum, avg_abs, avg_dz;

        always_comb
        begin
            diff     = XW'(samp_reg[i]) - XW'(prev_reg);
            diff_abs = diff[XW-1] ? -diff : diff;
            diff_dz  = (MW'($unsigned(diff_abs)) < MW'(motion_thr_reg)) ? '0 : diff;
            err      = diff_dz - XW'(avg_reg);
            // divide by four toward zero
            quarter  = err[XW-1] ? ((err + AVG_BIAS) >>> TMF_AVG_SHIFT)
                                 : (err >>> TMF_AVG_SHIFT);
            avg_sum  = XW'(avg_reg) + quarter;
            avg_abs  = avg_sum[XW-1] ? -avg_sum : avg_sum;
            avg_dz   = (MW'($unsigned(avg_abs)) < MW'(rest_thr_reg)) ? '0 : avg_sum;

            prev_next = enable_reg ? samp_reg[i] : '0;
            avg_next  = enable_reg ? AW'(avg_dz) : '0;
            motion_res[i] = enable_reg ? avg_dz[SW:0] : '0;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                prev_reg <= '0;
                avg_reg  <= '0;
            end
            else if (proc)
            begin
                prev_reg <= prev_next;
                avg_reg  <= avg_next;
            end
        end
    end

    // tilt smoothers, arithmetic shift rounds toward minus infinity
    logic signed [TW-1:0] tilt_a_reg, tilt_a_next;
    logic signed [TW-1:0] tilt_b_reg, tilt_b_next;
    logic signed [TW-1:0] tgt_a, tgt_b, err_a, err_b, sum_a, sum_b;

    always_comb
    begin
        tgt_a = TW'(tilt_offset_reg) - TW'(samp_reg[1]);
        tgt_b = -TW'(samp_reg[0]);
        err_a = tgt_a - tilt_a_reg;
        err_b = tgt_b - tilt_b_reg;
        sum_a = tilt_a_reg + (err_a >>> TMF_TILT_SHIFT);
        sum_b = tilt_b_reg + (err_b >>> TMF_TILT_SHIFT);
        tilt_a_next = enable_reg ? sum_a : '0;
        tilt_b_next = enable_reg ? sum_b : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_a_reg <= '0;
            tilt_b_reg <= '0;
        end
        else if (proc)
        begin
            tilt_a_reg <= tilt_a_next;
            tilt_b_reg <= tilt_b_next;
        end
    end

    // result register
    logic signed [SW:0] motion_x_reg, motion_y_reg, motion_z_reg;
    logic signed [SW:0] tilt_a_out_reg, tilt_b_out_reg;

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            motion_x_reg   <= motion_res[0];
            motion_y_reg   <= motion_res[1];
            motion_z_reg   <= motion_res[2];
            tilt_a_out_reg <= tilt_a_next[SW:0];
            tilt_b_out_reg <= tilt_b_next[SW:0];
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.motion_x = motion_x_reg;
    assign out_ch.motion_y = motion_y_reg;
    assign out_ch.motion_z = motion_z_reg;
    assign out_ch.tilt_a   = tilt_a_out_reg;
    assign out_ch.tilt_b   = tilt_b_out_reg;

endmodule

/* rtl/core/tmf_checker.sv */
// port-level checks of the tilt motion filter and their bind to the top level
// depends on tmf_pkg and tilt_motion_filter_macros.svh
`include "tilt_motion_filter_macros.svh"

module tmf_checker
    import tmf_pkg::*;
#(
    parameter int SAMPLE_BITS = TMF_SAMPLE_BITS
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [SAMPLE_BITS:0]  motion_x,
    input logic [SAMPLE_BITS:0]  motion_y,
    input logic [SAMPLE_BITS:0]  motion_z,
    input logic [SAMPLE_BITS:0]  tilt_a,
    input logic [SAMPLE_BITS:0]  tilt_b,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [TMF_ADDR_W-1:0] paddr,
    input logic [TMF_DATA_W-1:0] pwdata,
    input logic [TMF_DATA_W-1:0] prdata
);

    logic in_acc;
    logic thr_wr;

    assign in_acc = in_valid && in_ready;
    assign thr_wr = psel && penable && pwrite && (paddr[3:2] == REG_MOTION_THR);

    // a held result word keeps its payload
    `TMF_ASSERT_NEXT(a_hold_word, out_valid && !out_ready,
        out_valid && $stable(motion_x) && $stable(motion_y) && $stable(motion_z)
        && $stable(tilt_a) && $stable(tilt_b))

    // a new result word follows its sample through the input register and the result register
    `TMF_ASSERT_SAME(a_word_latency, $rose(out_valid), $past($past(in_acc)))

    // input stalls only when both registers are full and the result is held
    `TMF_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready)

    // threshold written over the port reads back
    `TMF_ASSERT_SAME(a_thr_readback,
        psel && !pwrite && (paddr == $past(paddr)) && $past(rst_n) && $past(thr_wr),
        prdata[TMF_CFG_W-1:0] == $past(pwdata[TMF_CFG_W-1:0]))

endmodule

bind tilt_motion_filter tmf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .motion_x  (out_ch.motion_x),
    .motion_y  (out_ch.motion_y),
    .motion_z  (out_ch.motion_z),
    .tilt_a    (out_ch.tilt_a),
    .tilt_b    (out_ch.tilt_b),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
